FILE: src/mflg_pkg.sv
// ---------------------------------------------------------------------------
// mflg_pkg
// Shared widths, register map, datapath operations and status bundle of the
// level-graph maximum-flow block.
// ---------------------------------------------------------------------------
package mflg_pkg;

  // Default sizes of the graph store.
  localparam int DEF_MAX_NODES = 512;
  localparam int DEF_MAX_EDGES = 1024;

  // Fixed field widths.
  localparam int NODE_NUM_W = 10;
  localparam int CAP_W      = 30;
  localparam int FLOW_W     = 40;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [NODE_NUM_W-1:0] NODE_COUNT_RESET = 10'd2;

  // Largest residual value; also the starting point of a bottleneck search.
  localparam logic [CAP_W-1:0] CAP_MASK = '1;

  // One operation per cycle, issued by the controller to the datapath.
  typedef enum logic [5:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_FIRST,
    OP_RA,
    OP_WA,
    OP_RB,
    OP_WB,
    OP_SOLVE,
    OP_VCLR,
    OP_BSEED,
    OP_BHEAD,
    OP_BU,
    OP_BE,
    OP_BSCAN,
    OP_BV,
    OP_BCHK,
    OP_CIRD,
    OP_CIWR,
    OP_DTOP,
    OP_DE,
    OP_DSCAN,
    OP_DV,
    OP_DCHK,
    OP_DADV,
    OP_DPOP,
    OP_DPOP2,
    OP_AMRS,
    OP_AMRR,
    OP_AMMN,
    OP_AURS,
    OP_AURR,
    OP_AUW1,
    OP_AUW2,
    OP_AFIN,
    OP_EMIT
  } dp_op_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic in_ok;
    logic last_in;
    logic last_lat;
    logic n_ok;
    logic clr_last;
    logic head_lt_tail;
    logic sink_hit;
    logic e_valid;
    logic ci_last;
    logic at_sink;
    logic match;
    logic can_push;
    logic depth_zero;
    logic aug_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: src/max_flow_level_graph.sv
// ---------------------------------------------------------------------------
// max_flow_level_graph
// Maximum flow from node 1 to node node_count by level passes and
// stack-driven augmenting searches.
// ---------------------------------------------------------------------------
// Edges are loaded one item at a time; each stored edge is accepted and then
// written with two read/write pairs on the list-head memory, and an edge that
// is not stored is only accepted. After the item marked last_edge the block
// solves: every level pass clears the visited marks of all MAX_NODES nodes and
// then queues nodes and scans their edges, cursor setup reads and writes the
// cursor of every node up to the sink, the search advances or retreats one node
// at a time and skips over unusable edges, and each augmenting path is walked
// once for its bottleneck and once to update the residuals.
// The steps are paced by the registered read ports of the graph memories. The
// result is then held in an output register, and a clearing pass over all
// MAX_NODES list heads follows each result and each reset, during which no
// item is taken. Configuration writes are accepted at any time.
module max_flow_level_graph #(
  parameter int MAX_NODES = mflg_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = mflg_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mflg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mflg_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mflg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mflg_pkg::NODE_NUM_W-1:0]  from_node,
  input  logic [mflg_pkg::NODE_NUM_W-1:0]  to_node,
  input  logic [mflg_pkg::CAP_W-1:0]       capacity,
  input  logic                             last_edge,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mflg_pkg::FLOW_W-1:0]      max_flow
);

  import mflg_pkg::*;

  logic [NODE_NUM_W-1:0] node_count;
  logic                  reg_sel;
  dp_op_t                op;
  dp_status_t            st;

  // Register file: a single node count register, decoded at offsets zero to three.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_NODE_COUNT[CFG_ADDR_W-1]);
  assign prdata  = reg_sel ? CFG_DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count <= pwdata[NODE_NUM_W-1:0];
    end
  end

  // Sequencer.
  mflg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .st(st), .op(op)
  );

  // Datapath with the graph memories.
  mflg_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .op(op), .st(st), .node_count(node_count),
    .from_node(from_node), .to_node(to_node), .capacity(capacity), .last_edge(last_edge),
    .out_valid(out_valid), .out_stall(out_stall), .max_flow(max_flow)
  );

endmodule

FILE: src/mflg_ram.sv
// ---------------------------------------------------------------------------
// mflg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module mflg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mflg_ctrl.sv
// ---------------------------------------------------------------------------
// mflg_ctrl
// Sequencer of the flow block: edge loading, level passes, augmenting
// searches, bottleneck updates, result hand-off and store clearing.
// ---------------------------------------------------------------------------
module mflg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mflg_pkg::dp_status_t st,
  output mflg_pkg::dp_op_t    op
);

  import mflg_pkg::*;

  typedef enum logic [33:0] {
    S_CLR   = 34'b1 << 0,
    S_IDLE  = 34'b1 << 1,
    S_RA    = 34'b1 << 2,
    S_WA    = 34'b1 << 3,
    S_RB    = 34'b1 << 4,
    S_WB    = 34'b1 << 5,
    S_SOLVE = 34'b1 << 6,
    S_VCLR  = 34'b1 << 7,
    S_BSEED = 34'b1 << 8,
    S_BHEAD = 34'b1 << 9,
    S_BU    = 34'b1 << 10,
    S_BE    = 34'b1 << 11,
    S_BSCAN = 34'b1 << 12,
    S_BV    = 34'b1 << 13,
    S_BCHK  = 34'b1 << 14,
    S_CIRD  = 34'b1 << 15,
    S_CIWR  = 34'b1 << 16,
    S_DTOP  = 34'b1 << 17,
    S_DE    = 34'b1 << 18,
    S_DSCAN = 34'b1 << 19,
    S_DV    = 34'b1 << 20,
    S_DCHK  = 34'b1 << 21,
    S_DADV  = 34'b1 << 22,
    S_DPOP  = 34'b1 << 23,
    S_DPOP2 = 34'b1 << 24,
    S_AMRS  = 34'b1 << 25,
    S_AMRR  = 34'b1 << 26,
    S_AMMN  = 34'b1 << 27,
    S_AURS  = 34'b1 << 28,
    S_AURR  = 34'b1 << 29,
    S_AUW1  = 34'b1 << 30,
    S_AUW2  = 34'b1 << 31,
    S_AFIN  = 34'b1 << 32,
    S_EMIT  = 34'b1 << 33
  } state_t;

  state_t state;
  state_t state_next;

  // Items are taken only while waiting for the next edge.
  assign in_stall = (state != S_IDLE);

  // State register; reset starts the clearing pass of the list heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_CLR: begin
        op = OP_CLR_FIRST;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LATCH;
          if (st.in_ok) state_next = S_RA;
          else if (st.last_in) state_next = S_SOLVE;
        end
      end
      S_RA: begin
        op = OP_RA;
        state_next = S_WA;
      end
      S_WA: begin
        op = OP_WA;
        state_next = S_RB;
      end
      S_RB: begin
        op = OP_RB;
        state_next = S_WB;
      end
      S_WB: begin
        op = OP_WB;
        state_next = st.last_lat ? S_SOLVE : S_IDLE;
      end
      S_SOLVE: begin
        op = OP_SOLVE;
        state_next = st.n_ok ? S_VCLR : S_EMIT;
      end
      S_VCLR: begin
        op = OP_VCLR;
        if (st.clr_last) state_next = S_BSEED;
      end
      S_BSEED: begin
        op = OP_BSEED;
        state_next = S_BHEAD;
      end
      S_BHEAD: begin
        op = OP_BHEAD;
        if (st.head_lt_tail) state_next = S_BU;
        else state_next = st.sink_hit ? S_CIRD : S_EMIT;
      end
      S_BU: begin
        op = OP_BU;
        state_next = S_BE;
      end
      S_BE: begin
        op = OP_BE;
        state_next = S_BSCAN;
      end
      S_BSCAN: begin
        op = OP_BSCAN;
        state_next = st.e_valid ? S_BV : S_BHEAD;
      end
      S_BV: begin
        op = OP_BV;
        state_next = S_BCHK;
      end
      S_BCHK: begin
        op = OP_BCHK;
        state_next = S_BSCAN;
      end
      S_CIRD: begin
        op = OP_CIRD;
        state_next = S_CIWR;
      end
      S_CIWR: begin
        op = OP_CIWR;
        state_next = st.ci_last ? S_DTOP : S_CIRD;
      end
      S_DTOP: begin
        op = OP_DTOP;
        state_next = st.at_sink ? S_AMRS : S_DE;
      end
      S_DE: begin
        op = OP_DE;
        state_next = S_DSCAN;
      end
      S_DSCAN: begin
        op = OP_DSCAN;
        state_next = st.e_valid ? S_DV : S_DADV;
      end
      S_DV: begin
        op = OP_DV;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        op = OP_DCHK;
        state_next = st.match ? S_DADV : S_DSCAN;
      end
      S_DADV: begin
        op = OP_DADV;
        if (st.can_push) state_next = S_DTOP;
        else state_next = st.depth_zero ? S_VCLR : S_DPOP;
      end
      S_DPOP: begin
        op = OP_DPOP;
        state_next = S_DPOP2;
      end
      S_DPOP2: begin
        op = OP_DPOP2;
        state_next = S_DTOP;
      end
      S_AMRS: begin
        op = OP_AMRS;
        state_next = S_AMRR;
      end
      S_AMRR: begin
        op = OP_AMRR;
        state_next = S_AMMN;
      end
      S_AMMN: begin
        op = OP_AMMN;
        state_next = st.aug_last ? S_AURS : S_AMRS;
      end
      S_AURS: begin
        op = OP_AURS;
        state_next = S_AURR;
      end
      S_AURR: begin
        op = OP_AURR;
        state_next = S_AUW1;
      end
      S_AUW1: begin
        op = OP_AUW1;
        state_next = S_AUW2;
      end
      S_AUW2: begin
        op = OP_AUW2;
        state_next = st.aug_last ? S_AFIN : S_AURS;
      end
      S_AFIN: begin
        op = OP_AFIN;
        state_next = S_DTOP;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          op = OP_EMIT;
          state_next = S_CLR;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

FILE: src/mflg_dp.sv
// ---------------------------------------------------------------------------
// mflg_dp
// Datapath of the flow block: graph, level, queue, stack and cursor memories,
// search registers, bottleneck arithmetic and the output register.
// ---------------------------------------------------------------------------
module mflg_dp #(
  parameter int MAX_NODES = mflg_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = mflg_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mflg_pkg::dp_op_t                 op,
  output mflg_pkg::dp_status_t             st,
  input  logic [mflg_pkg::NODE_NUM_W-1:0]  node_count,
  input  logic [mflg_pkg::NODE_NUM_W-1:0]  from_node,
  input  logic [mflg_pkg::NODE_NUM_W-1:0]  to_node,
  input  logic [mflg_pkg::CAP_W-1:0]       capacity,
  input  logic                             last_edge,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mflg_pkg::FLOW_W-1:0]      max_flow
);

  import mflg_pkg::*;

  localparam int SLOTS  = 2 * MAX_EDGES;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);

  // Latched edge and search registers.
  logic [NODE_W-1:0] a_lat, b_lat;
  logic [CAP_W-1:0]  cap_lat;
  logic              last_lat;
  logic [ECNT_W-1:0] stored;
  logic [NCNT_W-1:0] n;
  logic [NODE_W-1:0] idx;
  logic [NCNT_W-1:0] head, tail;
  logic              sink_hit;
  logic [NODE_W-1:0] u, v;
  logic [LINK_W-1:0] e, nx;
  logic [NCNT_W-1:0] lu;
  logic [CAP_W-1:0]  r, f;
  logic [NCNT_W-1:0] depth;
  logic [SLOT_W-1:0] s;
  logic [FLOW_W-1:0] flow;

  // Memory ports.
  logic tgt_we, res_we, nxt_we, first_we, lvl_we, vis_we, q_we, stk_we, cur_we;
  logic [SLOT_W-1:0] tgt_wa, tgt_ra, res_wa, res_ra, nxt_wa, nxt_ra;
  logic [NODE_W-1:0] first_wa, first_ra, lvl_wa, lvl_ra, vis_wa, vis_ra;
  logic [NODE_W-1:0] q_wa, q_ra, stk_wa, stk_ra, cur_wa, cur_ra;
  logic [NODE_W-1:0] tgt_wd, tgt_rd, q_wd, q_rd;
  logic [CAP_W-1:0]  res_wd, res_rd;
  logic [LINK_W-1:0] nxt_wd, nxt_rd, first_wd, first_rd, cur_wd, cur_rd;
  logic [NCNT_W-1:0] lvl_wd, lvl_rd;
  logic              vis_wd, vis_rd;
  logic [SLOT_W-1:0] stk_wd, stk_rd;

  // Derived values.
  logic [SLOT_W-1:0] fslot, rslot;
  logic [NODE_W-1:0] sink;
  logic [NCNT_W-1:0] n_sat, depth_m1;
  logic              a_ok, b_ok, bfs_take;

  assign fslot    = SLOT_W'({stored, 1'b0});
  assign rslot    = fslot | SLOT_W'(1);
  assign sink     = NODE_W'(n - NCNT_W'(1));
  assign depth_m1 = depth - NCNT_W'(1);
  assign n_sat    = (32'(node_count) > MAX_NODES) ? NCNT_W'(MAX_NODES) : NCNT_W'(node_count);
  assign a_ok     = (from_node != '0) && (32'(from_node) <= MAX_NODES);
  assign b_ok     = (to_node != '0) && (32'(to_node) <= MAX_NODES);
  assign bfs_take = (NCNT_W'(v) < n) && (r != '0) && !vis_rd && (32'(tail) < MAX_NODES);

  // Status towards the controller.
  always_comb begin
    st.in_ok        = a_ok && b_ok && (32'(stored) < MAX_EDGES);
    st.last_in      = last_edge;
    st.last_lat     = last_lat;
    st.n_ok         = (32'(node_count) >= 2);
    st.clr_last     = (idx == NODE_W'(MAX_NODES - 1));
    st.head_lt_tail = (head < tail);
    st.sink_hit     = sink_hit;
    st.e_valid      = (e < LINK_NULL);
    st.ci_last      = (idx == sink);
    st.at_sink      = (u == sink) && (depth != '0);
    st.match        = (NCNT_W'(v) < n) && (r != '0) && vis_rd && (lvl_rd == lu + NCNT_W'(1));
    st.can_push     = (e < LINK_NULL) && (32'(depth) < MAX_NODES);
    st.depth_zero   = (depth == '0);
    st.aug_last     = (idx == NODE_W'(depth_m1));
    st.out_busy     = out_valid && out_stall;
  end

  // Memory addressing per operation.
  always_comb begin
    tgt_we = 1'b0; res_we = 1'b0; nxt_we = 1'b0; first_we = 1'b0; lvl_we = 1'b0;
    vis_we = 1'b0; q_we = 1'b0; stk_we = 1'b0; cur_we = 1'b0;
    tgt_wa = '0; tgt_ra = '0; res_wa = '0; res_ra = '0; nxt_wa = '0; nxt_ra = '0;
    first_wa = '0; first_ra = '0; lvl_wa = '0; lvl_ra = '0; vis_wa = '0; vis_ra = '0;
    q_wa = '0; q_ra = '0; stk_wa = '0; stk_ra = '0; cur_wa = '0; cur_ra = '0;
    tgt_wd = '0; res_wd = '0; nxt_wd = '0; first_wd = '0; lvl_wd = '0; vis_wd = 1'b0;
    q_wd = '0; stk_wd = '0; cur_wd = '0;
    case (op)
      OP_CLR_FIRST: begin
        first_we = 1'b1; first_wa = idx; first_wd = LINK_NULL;
      end
      OP_RA: first_ra = a_lat;
      OP_WA: begin
        tgt_we = 1'b1; tgt_wa = fslot; tgt_wd = b_lat;
        res_we = 1'b1; res_wa = fslot; res_wd = cap_lat;
        nxt_we = 1'b1; nxt_wa = fslot; nxt_wd = first_rd;
        first_we = 1'b1; first_wa = a_lat; first_wd = LINK_W'(fslot);
      end
      OP_RB: first_ra = b_lat;
      OP_WB: begin
        tgt_we = 1'b1; tgt_wa = rslot; tgt_wd = a_lat;
        res_we = 1'b1; res_wa = rslot; res_wd = '0;
        nxt_we = 1'b1; nxt_wa = rslot; nxt_wd = first_rd;
        first_we = 1'b1; first_wa = b_lat; first_wd = LINK_W'(rslot);
      end
      OP_VCLR: begin
        vis_we = 1'b1; vis_wa = idx; vis_wd = 1'b0;
      end
      OP_BSEED: begin
        vis_we = 1'b1; vis_wa = '0; vis_wd = 1'b1;
        lvl_we = 1'b1; lvl_wa = '0; lvl_wd = '0;
        q_we = 1'b1; q_wa = '0; q_wd = '0;
      end
      OP_BHEAD: q_ra = head[NODE_W-1:0];
      OP_BU: begin
        first_ra = q_rd; lvl_ra = q_rd;
      end
      OP_BSCAN, OP_DSCAN: begin
        tgt_ra = e[SLOT_W-1:0]; res_ra = e[SLOT_W-1:0]; nxt_ra = e[SLOT_W-1:0];
      end
      OP_BV: vis_ra = tgt_rd;
      OP_BCHK: begin
        if (bfs_take) begin
          vis_we = 1'b1; vis_wa = v; vis_wd = 1'b1;
          lvl_we = 1'b1; lvl_wa = v; lvl_wd = lu + NCNT_W'(1);
          q_we = 1'b1; q_wa = tail[NODE_W-1:0]; q_wd = v;
        end
      end
      OP_CIRD: first_ra = idx;
      OP_CIWR: begin
        cur_we = 1'b1; cur_wa = idx; cur_wd = first_rd;
      end
      OP_DTOP: begin
        cur_ra = u; lvl_ra = u;
      end
      OP_DV: begin
        vis_ra = tgt_rd; lvl_ra = tgt_rd;
      end
      OP_DADV: begin
        cur_we = 1'b1; cur_wa = u; cur_wd = e;
        if (st.can_push) begin
          stk_we = 1'b1; stk_wa = depth[NODE_W-1:0]; stk_wd = e[SLOT_W-1:0];
        end else begin
          vis_we = 1'b1; vis_wa = u; vis_wd = 1'b0;
          stk_ra = depth_m1[NODE_W-1:0];
        end
      end
      OP_DPOP: begin
        tgt_ra = stk_rd ^ SLOT_W'(1); nxt_ra = stk_rd;
      end
      OP_DPOP2: begin
        cur_we = 1'b1; cur_wa = tgt_rd; cur_wd = nxt_rd;
      end
      OP_AMRS, OP_AURS: stk_ra = idx;
      OP_AMRR, OP_AURR: res_ra = stk_rd;
      OP_AUW1: begin
        res_we = 1'b1; res_wa = s; res_wd = res_rd - f;
        res_ra = s ^ SLOT_W'(1);
      end
      OP_AUW2: begin
        res_we = 1'b1; res_wa = s ^ SLOT_W'(1); res_wd = res_rd + f;
      end
      default: ;
    endcase
  end

  // Result valid flag: raised on emit, dropped once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Search and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored    <= '0;
      idx       <= '0;
    end else begin
      case (op)
        OP_LATCH: begin
          a_lat    <= NODE_W'(from_node) - NODE_W'(1);
          b_lat    <= NODE_W'(to_node) - NODE_W'(1);
          cap_lat  <= capacity;
          last_lat <= last_edge;
        end
        OP_CLR_FIRST, OP_VCLR: idx <= st.clr_last ? '0 : idx + NODE_W'(1);
        OP_WB: stored <= stored + ECNT_W'(1);
        OP_SOLVE: begin
          flow <= '0;
          n    <= n_sat;
        end
        OP_BSEED: begin
          head     <= '0;
          tail     <= NCNT_W'(1);
          sink_hit <= 1'b0;
        end
        OP_BHEAD: if (head < tail) head <= head + NCNT_W'(1);
        OP_BU: u <= q_rd;
        OP_BE: begin
          e  <= first_rd;
          lu <= lvl_rd;
        end
        OP_DE: begin
          e  <= cur_rd;
          lu <= lvl_rd;
        end
        OP_BV, OP_DV: begin
          v  <= tgt_rd;
          r  <= res_rd;
          nx <= nxt_rd;
        end
        OP_BCHK: begin
          if (bfs_take) begin
            tail <= tail + NCNT_W'(1);
            if (v == sink) sink_hit <= 1'b1;
          end
          e <= nx;
        end
        OP_CIWR: begin
          if (st.ci_last) begin
            idx   <= '0;
            depth <= '0;
            u     <= '0;
          end else begin
            idx <= idx + NODE_W'(1);
          end
        end
        OP_DTOP: if (st.at_sink) f <= CAP_MASK;
        OP_DCHK: if (!st.match) e <= nx;
        OP_DADV: begin
          if (st.can_push) begin
            depth <= depth + NCNT_W'(1);
            u     <= v;
          end else if (depth != '0) begin
            depth <= depth_m1;
          end
        end
        OP_DPOP2: u <= tgt_rd;
        OP_AMRR, OP_AURR: s <= stk_rd;
        OP_AMMN: begin
          if (res_rd < f) f <= res_rd;
          idx <= st.aug_last ? '0 : idx + NODE_W'(1);
        end
        OP_AUW2: idx <= st.aug_last ? '0 : idx + NODE_W'(1);
        OP_AFIN: begin
          flow  <= flow + FLOW_W'(f);
          depth <= '0;
          u     <= '0;
        end
        OP_EMIT: begin
          max_flow  <= flow;
          stored    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Edge store: target, residual and next link of every slot.
  mflg_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd)
  );
  mflg_ram #(.WIDTH(CAP_W), .DEPTH(SLOTS)) u_res (
    .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd)
  );
  mflg_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd)
  );

  // Per-node stores.
  mflg_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_first (
    .clk(clk), .we(first_we), .waddr(first_wa), .wdata(first_wd),
    .raddr(first_ra), .rdata(first_rd)
  );
  mflg_ram #(.WIDTH(NCNT_W), .DEPTH(MAX_NODES)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd)
  );
  mflg_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  mflg_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );
  mflg_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );
  mflg_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_cursor (
    .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd)
  );

endmodule

FILE: src/mflg_checker.sv
// ---------------------------------------------------------------------------
// mflg_checker
// Port-level checks of the flow block, bound to its top level.
// ---------------------------------------------------------------------------
module mflg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_edge,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] max_flow
);

  // A waiting result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_flow))
    else $error("result changed or dropped while stalled");

  // The clearing pass after reset holds off input.
  a_reset_clear: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during the clearing pass after reset");

  // A last edge starts the solve, so no item follows directly.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_edge |=> in_stall)
    else $error("item taken directly after a last edge");

  // A new result appears only while the store is being cleared.
  a_result_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall)
    else $error("result issued without clearing the store");

endmodule

bind max_flow_level_graph mflg_checker u_mflg_checker (.*);
